### rtl/idtc_pkg.sv
// Shared types, opcodes and divide-by-three helpers for the dual timebase clock.
`timescale 1ns / 1ps
package idtc_pkg;

  localparam int OP_W        = 4;
  localparam int CYC_W       = 32;
  localparam int VAL_W       = 64;
  localparam int NPT_W       = 20;
  localparam int DIV_CHUNK   = 16;
  localparam int DIV_STEPS   = VAL_W / DIV_CHUNK;
  localparam int DIV_IDX_W   = $clog2(DIV_STEPS);
  localparam int DIV_SHIFT   = 19;

  localparam logic [NPT_W-1:0]     NPT_RESET   = 20'd100000;
  // ceil(2^19 / 3); exact quotient for any dividend below 2^19
  localparam logic [DIV_CHUNK+1:0] DIV3_RECIP  = 18'd174763;

  typedef enum logic [OP_W-1:0] {
    OP_GNSS_EDGE  = 4'd0,
    OP_OCXO_EDGE  = 4'd1,
    OP_READ_CYC   = 4'd2,
    OP_CYC_NS     = 4'd3,
    OP_GNSS_NS    = 4'd4,
    OP_OCXO_NS    = 4'd5,
    OP_ZERO       = 4'd6,
    OP_GNSS_TICKS = 4'd7,
    OP_OCXO_TICKS = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    KIND_DIRECT = 2'd0,
    KIND_CYC_NS = 2'd1,
    KIND_DOM_NS = 2'd2
  } kind_t;

  // after the ledger: a = direct value, extended cycles or tick count
  typedef struct packed {
    kind_t              kind;
    logic [VAL_W-1:0]   a;
    logic [CYC_W-1:0]   delta;
  } front_t;

  // after the multiply stage
  typedef struct packed {
    kind_t              kind;
    logic [VAL_W-1:0]   a;
    logic [51:0]        plo;
    logic [CYC_W-1:0]   phi;
    logic [VAL_W-1:0]   num;
  } mul_t;

  // divider stages: num is replaced chunk by chunk with the quotient
  typedef struct packed {
    kind_t              kind;
    logic [VAL_W-1:0]   val;
    logic [VAL_W-1:0]   num;
    logic [1:0]         rem;
  } div_t;

  function automatic logic [DIV_CHUNK-1:0] div3_q(logic [DIV_CHUNK+1:0] n);
    logic [2*DIV_CHUNK+3:0] p;
    p = (2*DIV_CHUNK+4)'(n) * (2*DIV_CHUNK+4)'(DIV3_RECIP);
    return p[DIV_SHIFT+DIV_CHUNK-1:DIV_SHIFT];
  endfunction

  function automatic div_t div3_step(div_t d, logic [DIV_IDX_W-1:0] c);
    div_t                 r;
    logic [DIV_CHUNK+1:0] cur;
    logic [DIV_CHUNK-1:0] q;
    logic [DIV_CHUNK+1:0] left;
    r    = d;
    cur  = {d.rem, d.num[c*DIV_CHUNK +: DIV_CHUNK]};
    q    = div3_q(cur);
    left = cur - {1'b0, q, 1'b0} - {2'b00, q};
    r.num[c*DIV_CHUNK +: DIV_CHUNK] = q;
    r.rem = left[1:0];
    return r;
  endfunction

endpackage

### rtl/idtc_ledger.sv
// Counter ledger: cycle extension, edge counts, baselines and the first pipeline register.
`timescale 1ns / 1ps
module idtc_ledger import idtc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [OP_W-1:0]  opcode,
  input  logic [CYC_W-1:0] cycle_now,
  output front_t           front,
  output logic             front_valid,
  input  logic             front_ready
);

  logic [VAL_W-1:0] cycles_extended, cycles_extended_next;
  logic [CYC_W-1:0] cycles_last_sample, cycles_last_sample_next;
  logic [VAL_W-1:0] gnss_ticks, gnss_ticks_next;
  logic [VAL_W-1:0] ocxo_ticks, ocxo_ticks_next;
  logic [CYC_W-1:0] gnss_baseline, gnss_baseline_next;
  logic [CYC_W-1:0] ocxo_baseline, ocxo_baseline_next;
  logic [VAL_W-1:0] ext_sum;
  front_t           front_next;
  logic             accept;

  assign in_ready = !front_valid || front_ready;
  assign accept   = in_valid && in_ready;
  assign ext_sum  = cycles_extended + {32'b0, cycle_now - cycles_last_sample};

  always_comb begin
    cycles_extended_next    = cycles_extended;
    cycles_last_sample_next = cycles_last_sample;
    gnss_ticks_next         = gnss_ticks;
    ocxo_ticks_next         = ocxo_ticks;
    gnss_baseline_next      = gnss_baseline;
    ocxo_baseline_next      = ocxo_baseline;
    front_next.kind         = KIND_DIRECT;
    front_next.a            = '0;
    front_next.delta        = '0;
    case (op_t'(opcode))
      OP_GNSS_EDGE: begin
        gnss_ticks_next    = gnss_ticks + 64'd1;
        gnss_baseline_next = cycle_now;
        front_next.a       = gnss_ticks + 64'd1;
      end
      OP_OCXO_EDGE: begin
        ocxo_ticks_next    = ocxo_ticks + 64'd1;
        ocxo_baseline_next = cycle_now;
        front_next.a       = ocxo_ticks + 64'd1;
      end
      OP_READ_CYC: begin
        cycles_extended_next    = ext_sum;
        cycles_last_sample_next = cycle_now;
        front_next.a            = ext_sum;
      end
      OP_CYC_NS: begin
        cycles_extended_next    = ext_sum;
        cycles_last_sample_next = cycle_now;
        front_next.kind         = KIND_CYC_NS;
        front_next.a            = ext_sum;
      end
      OP_GNSS_NS: begin
        front_next.kind  = KIND_DOM_NS;
        front_next.a     = gnss_ticks;
        front_next.delta = cycle_now - gnss_baseline;
      end
      OP_OCXO_NS: begin
        front_next.kind  = KIND_DOM_NS;
        front_next.a     = ocxo_ticks;
        front_next.delta = cycle_now - ocxo_baseline;
      end
      OP_ZERO: begin
        cycles_extended_next    = '0;
        cycles_last_sample_next = cycle_now;
        gnss_ticks_next         = '0;
        ocxo_ticks_next         = '0;
        gnss_baseline_next      = cycle_now;
        ocxo_baseline_next      = cycle_now;
      end
      OP_GNSS_TICKS: front_next.a = gnss_ticks;
      OP_OCXO_TICKS: front_next.a = ocxo_ticks;
      default: front_next.a = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cycles_extended    <= '0;
      cycles_last_sample <= '0;
      gnss_ticks         <= '0;
      ocxo_ticks         <= '0;
      gnss_baseline      <= '0;
      ocxo_baseline      <= '0;
      front_valid        <= 1'b0;
    end else begin
      if (accept) begin
        cycles_extended    <= cycles_extended_next;
        cycles_last_sample <= cycles_last_sample_next;
        gnss_ticks         <= gnss_ticks_next;
        ocxo_ticks         <= ocxo_ticks_next;
        gnss_baseline      <= gnss_baseline_next;
        ocxo_baseline      <= ocxo_baseline_next;
      end
      if (in_ready) begin
        front_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front <= front_next;
    end
  end

endmodule

### rtl/idtc_arith.sv
// Scaling pipeline: tick multiply, times-five, and a chunked divide by three.
`timescale 1ns / 1ps
module idtc_arith import idtc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [NPT_W-1:0] ns_per_tick,
  input  front_t           front,
  input  logic             front_valid,
  output logic             front_ready,
  output div_t             result,
  output logic             result_valid,
  input  logic             result_ready
);

  mul_t             mul;
  logic             mul_valid;
  mul_t             mul_next;
  logic [51:0]      hi_full;
  logic [34:0]      delta5;
  div_t             stg [DIV_STEPS+1];
  logic [DIV_STEPS:0] stg_valid;
  logic [DIV_STEPS:0] stg_load;
  div_t             stg0_next;

  always_comb begin
    stg_load[DIV_STEPS] = !stg_valid[DIV_STEPS] || result_ready;
    for (int i = DIV_STEPS - 1; i >= 0; i--) begin
      stg_load[i] = !stg_valid[i] || stg_load[i+1];
    end
  end

  assign front_ready = !mul_valid || stg_load[0];

  always_comb begin
    mul_next.kind = front.kind;
    mul_next.a    = front.a;
    mul_next.plo  = 52'(front.a[31:0]) * 52'(ns_per_tick);
    hi_full       = 52'(front.a[63:32]) * 52'(ns_per_tick);
    mul_next.phi  = hi_full[31:0];
    delta5        = {front.delta, 2'b00} + {3'b000, front.delta};
    if (front.kind == KIND_CYC_NS) begin
      mul_next.num = {front.a[61:0], 2'b00} + front.a;
    end else begin
      mul_next.num = {29'b0, delta5};
    end
  end

  always_comb begin
    stg0_next.kind = mul.kind;
    stg0_next.num  = mul.num;
    stg0_next.rem  = 2'b00;
    if (mul.kind == KIND_DIRECT) begin
      stg0_next.val = mul.a;
    end else begin
      stg0_next.val = {12'b0, mul.plo} + {mul.phi, 32'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      stg_valid <= '0;
    end else begin
      if (front_ready) begin
        mul_valid <= front_valid;
      end
      if (stg_load[0]) begin
        stg_valid[0] <= mul_valid;
      end
      for (int i = 1; i <= DIV_STEPS; i++) begin
        if (stg_load[i]) begin
          stg_valid[i] <= stg_valid[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (front_ready && front_valid) begin
      mul <= mul_next;
    end
    if (stg_load[0] && mul_valid) begin
      stg[0] <= stg0_next;
    end
    for (int i = 1; i <= DIV_STEPS; i++) begin
      if (stg_load[i] && stg_valid[i-1]) begin
        stg[i] <= div3_step(stg[i-1], DIV_IDX_W'(DIV_STEPS - i));
      end
    end
  end

  assign result       = stg[DIV_STEPS];
  assign result_valid = stg_valid[DIV_STEPS];

endmodule

### rtl/interpolated_dual_timebase_clock_unit.sv
// Top level of the interpolated dual timebase clock.
`timescale 1ns / 1ps
// Usage:
//   s_* carries one command per transfer: opcode in s_tdata[3:0], the sampled
//   free-running cycle counter in s_tdata[35:4]. Every command gives exactly
//   one 64-bit result on m_* (m_tdata), in command order.
//   cfg_* writes ns_per_tick (20 bits); cfg_ready is always high. Write it
//   only while no command is in flight.
// Pipeline: a command passes the ledger register, multiply stage, sum stage,
//   four divide-by-three steps and the output register. Throughput: one command
//   per cycle while m_tready stays high; the counter ledger updates in the
//   accept cycle, so back-to-back commands see each other.
// Reset: rst (synchronous) clears all counters, baselines and the pipeline
//   and sets ns_per_tick to 100000; s_tready is high right after reset.
// Stall: when m_tready is low the result holds in the output register and
//   the pipeline keeps accepting until every stage is full, then s_tready
//   drops until the receiver takes a transfer.
module interpolated_dual_timebase_clock_unit import idtc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // opcode[3:0], cycle_now[35:4], zero pad[39:36]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // value[63:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [19:0] cfg_data   // ns_per_tick[19:0]
);

  logic [NPT_W-1:0] ns_per_tick;
  front_t           front;
  logic             front_valid;
  logic             front_ready;
  div_t             result;
  logic             result_valid;
  logic             out_load;
  logic [VAL_W-1:0] interp;
  logic [VAL_W-1:0] value_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ns_per_tick <= NPT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ns_per_tick <= cfg_data;
    end
  end

  idtc_ledger u_ledger (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .opcode      (s_tdata[3:0]),
    .cycle_now   (s_tdata[35:4]),
    .front       (front),
    .front_valid (front_valid),
    .front_ready (front_ready)
  );

  idtc_arith u_arith (
    .clk          (clk),
    .rst          (rst),
    .ns_per_tick  (ns_per_tick),
    .front        (front),
    .front_valid  (front_valid),
    .front_ready  (front_ready),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (out_load)
  );

  assign out_load = !m_tvalid || m_tready;

  always_comb begin
    if (result.num > {44'b0, ns_per_tick}) begin
      interp = {44'b0, ns_per_tick};
    end else begin
      interp = result.num;
    end
    case (result.kind)
      KIND_DIRECT: value_next = result.val;
      KIND_CYC_NS: value_next = result.num;
      KIND_DOM_NS: value_next = result.val + interp;
      default:     value_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && result_valid) begin
      m_tdata <= value_next;
    end
  end

endmodule

### rtl/idtc_checker.sv
// Port-level checker for the dual timebase clock, bound to the top level.
`timescale 1ns / 1ps
module idtc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // pipeline and output are empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("not empty after reset");

  // input backpressure only comes from a stalled output
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output stall");

  // a stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output dropped or changed while stalled");

  // the config channel never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

endmodule

bind interpolated_dual_timebase_clock_unit idtc_checker u_idtc_checker (.*);

### tb/interpolated_dual_timebase_clock_unit_tb.sv
// Testbench for the interpolated dual timebase clock: predicted results vs. streamed output.
`timescale 1ns / 1ps
module interpolated_dual_timebase_clock_unit_tb;
  import idtc_pkg::*;

  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 400000;

  class timebase_ledger;
    bit [NPT_W-1:0] ns_per_tick;
    bit [VAL_W-1:0] cyc_ext;
    bit [CYC_W-1:0] cyc_last;
    bit [VAL_W-1:0] gnss_ticks;
    bit [VAL_W-1:0] ocxo_ticks;
    bit [CYC_W-1:0] gnss_base;
    bit [CYC_W-1:0] ocxo_base;
    bit [VAL_W-1:0] expected_values[$];
    int             errors;

    function new();
      ns_per_tick = NPT_RESET;
      cyc_ext     = '0;
      cyc_last    = '0;
      gnss_ticks  = '0;
      ocxo_ticks  = '0;
      gnss_base   = '0;
      ocxo_base   = '0;
      errors      = 0;
    endfunction

    function void set_ns_per_tick(bit [NPT_W-1:0] npt);
      ns_per_tick = npt;
    endfunction

    function bit [VAL_W-1:0] extend(bit [CYC_W-1:0] now);
      cyc_ext  = cyc_ext + {32'd0, now - cyc_last};
      cyc_last = now;
      return cyc_ext;
    endfunction

    function bit [VAL_W-1:0] domain_time(bit [VAL_W-1:0] ticks, bit [CYC_W-1:0] base,
                                         bit [CYC_W-1:0] now);
      bit [VAL_W-1:0] delta;
      bit [VAL_W-1:0] frac;
      bit [VAL_W-1:0] npt;
      npt   = {44'd0, ns_per_tick};
      delta = {32'd0, now - base};
      frac  = (delta * 64'd5) / 64'd3;
      if (frac > npt) frac = npt;
      return ticks * npt + frac;
    endfunction

    function void note_command(bit [OP_W-1:0] op, bit [CYC_W-1:0] now);
      bit [VAL_W-1:0] v;
      v = '0;
      case (op)
        OP_GNSS_EDGE: begin
          gnss_ticks = gnss_ticks + 64'd1;
          gnss_base  = now;
          v          = gnss_ticks;
        end
        OP_OCXO_EDGE: begin
          ocxo_ticks = ocxo_ticks + 64'd1;
          ocxo_base  = now;
          v          = ocxo_ticks;
        end
        OP_READ_CYC:   v = extend(now);
        OP_CYC_NS:     v = (extend(now) * 64'd5) / 64'd3;
        OP_GNSS_NS:    v = domain_time(gnss_ticks, gnss_base, now);
        OP_OCXO_NS:    v = domain_time(ocxo_ticks, ocxo_base, now);
        OP_ZERO: begin
          cyc_ext    = '0;
          cyc_last   = now;
          gnss_ticks = '0;
          ocxo_ticks = '0;
          gnss_base  = now;
          ocxo_base  = now;
        end
        OP_GNSS_TICKS: v = gnss_ticks;
        OP_OCXO_TICKS: v = ocxo_ticks;
        default:       v = '0;
      endcase
      expected_values.push_back(v);
    endfunction

    function void check_value(bit [VAL_W-1:0] got);
      bit [VAL_W-1:0] want;
      if (expected_values.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual 0x%016h", $time, got);
      end else begin
        want = expected_values.pop_front();
        if (want !== got) begin
          errors++;
          $display("%0t: value mismatch: expected 0x%016h, actual 0x%016h", $time, want, got);
        end
      end
    endfunction

    function int pending();
      return expected_values.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // opcode[3:0], cycle_now[35:4], zero pad[39:36]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // value[63:0]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [19:0] cfg_data = '0;  // ns_per_tick[19:0]

  timebase_ledger ledger = new();
  bit             quiet = 1'b1;
  int             stall_left = 0;
  bit [CYC_W-1:0] cyc_counter = '0;
  int             cycle_count = 0;

  interpolated_dual_timebase_clock_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 4);
  endfunction

  // receiver: random stalls unless in a quiet stretch
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      m_tready   <= 1'b0;
      stall_left = gap_len() - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) ledger.check_value(m_tdata);
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_cmd(bit [OP_W-1:0] op, bit [CYC_W-1:0] now);
    int gap;
    s_tdata  <= {4'd0, now, op};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    ledger.note_command(op, now);
    gap = 0;
    if (!quiet && $urandom_range(0, 2) == 0) gap = gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_ns_per_tick(bit [NPT_W-1:0] npt);
    drain();
    cfg_data  <= npt;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    ledger.set_ns_per_tick(npt);
    cfg_valid <= 1'b0;
  endtask

  function automatic bit [OP_W-1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 22) return OP_GNSS_EDGE;
    if (r < 40) return OP_OCXO_EDGE;
    if (r < 50) return OP_READ_CYC;
    if (r < 58) return OP_CYC_NS;
    if (r < 70) return OP_GNSS_NS;
    if (r < 82) return OP_OCXO_NS;
    if (r < 85) return OP_ZERO;
    if (r < 90) return OP_GNSS_TICKS;
    if (r < 95) return OP_OCXO_TICKS;
    return OP_W'($urandom_range(9, 15));
  endfunction

  // mostly a counter advancing at a plausible rate, sometimes big jumps or noise
  task automatic run_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 75)
        cyc_counter += ($urandom_range(0, 3) == 0) ? $urandom_range(0, 700000)
                                                   : $urandom_range(0, 70000);
      else if (r < 88)
        cyc_counter += $urandom;
      else
        cyc_counter = $urandom;
      send_cmd(pick_op(), cyc_counter);
    end
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset state, counter wrap and interpolation around the clamp
    send_cmd(OP_GNSS_TICKS, 32'd0);
    send_cmd(OP_GNSS_NS, 32'd0);
    send_cmd(OP_OCXO_NS, 32'hFFFF_FFFF);
    send_cmd(OP_READ_CYC, 32'hFFFF_FFFF);
    send_cmd(OP_READ_CYC, 32'd5);
    send_cmd(OP_CYC_NS, 32'h8000_0000);
    send_cmd(OP_GNSS_EDGE, 32'd100);
    send_cmd(OP_GNSS_NS, 32'd100);
    send_cmd(OP_GNSS_NS, 32'd100 + 32'd59999);
    send_cmd(OP_GNSS_NS, 32'd100 + 32'd60000);
    send_cmd(OP_GNSS_NS, 32'd100 + 32'd60001);
    send_cmd(OP_OCXO_EDGE, 32'hFFFF_FFF0);
    send_cmd(OP_OCXO_NS, 32'h0000_0010);
    send_cmd(OP_OCXO_TICKS, 32'h0000_0010);
    send_cmd(OP_GNSS_EDGE, 32'hAAAA_5555);
    send_cmd(OP_GNSS_EDGE, 32'h5555_AAAA);
    send_cmd(OP_ZERO, 32'd12345);
    send_cmd(OP_READ_CYC, 32'd12345);
    send_cmd(OP_GNSS_NS, 32'd12345);
    send_cmd(OP_CYC_NS, 32'd12348);
    send_cmd(OP_W'(9), 32'hFFFF_FFFF);
    send_cmd(OP_W'(15), 32'hFFFF_FFFF);
    send_cmd(OP_OCXO_TICKS, 32'd0);

    // zero ns_per_tick: no base and no interpolation
    write_ns_per_tick(20'd0);
    send_cmd(OP_OCXO_EDGE, 32'd1000);
    send_cmd(OP_OCXO_NS, 32'd900000);

    quiet = 1'b0;
    run_random(90);
    write_ns_per_tick(20'd1);
    run_random(90);
    write_ns_per_tick(20'hFFFFF);
    run_random(90);
    quiet = 1'b1;
    write_ns_per_tick(NPT_RESET);
    run_random(90);
    quiet = 1'b0;
    write_ns_per_tick(NPT_W'($urandom_range(1, 20'hFFFFF)));
    run_random(95);
    write_ns_per_tick(NPT_W'($urandom_range(1000, 200000)));
    run_random(95);
    write_ns_per_tick(NPT_W'($urandom));
    run_random(80);

    drain();
    quiet = 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
